// ===== design/btde_pkg.sv =====
// Shared types and constants for the binary threshold, dilation and edge block.
package btde_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 11;
    localparam int THR_W     = 10;
    localparam int CHAN_W    = 8;
    localparam int SUM_W     = 10;
    localparam int EDGE_W    = 8;
    localparam int WIN_W     = 9;

    // Line store word: older row bit above newer row bit.
    localparam int MEM_W = 2;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int THR_RESET    = 383;

    localparam logic [EDGE_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [EDGE_W-1:0] EDGE_OFF = 8'd0;

    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_SUM_THRESHOLD = 2'd2
    } cfg_reg_t;

    typedef struct packed
    {
        opcode_t            opcode;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
    } pixel_in_t;

    typedef struct packed
    {
        logic [EDGE_W-1:0]  edge_value;
        logic               line_end;
        logic               frame_end;
    } edge_out_t;

    // Control for one raster step handed from the sequencer to the window stage.
    typedef struct packed
    {
        logic real_px;
        logic px_bit;
        logic top_en;
        logic mid_en;
        logic col_zero;
        logic due;
        logic frame_end;
    } step_ctl_t;

endpackage

// ===== design/btde_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module btde_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/btde_seq.sv =====
// Input side: thresholding, raster counters, flush handling and line store read issue.
module btde_seq import btde_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    localparam int ADDR_W = $clog2(MAX_WIDTH),
    localparam int WID_W  = $clog2(MAX_WIDTH + 1),
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1),
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              restart,
    input  logic [WID_W-1:0]  width,
    input  logic [HGT_W-1:0]  height,
    input  logic [THR_W-1:0]  threshold,
    input  logic              in_valid,
    output logic              in_stall,
    input  pixel_in_t         in_data,
    input  logic              take,
    output logic              issue,
    output step_ctl_t         step,
    output logic [ADDR_W-1:0] step_addr
);

    logic [ADDR_W-1:0] col_reg;
    logic [ADDR_W-1:0] col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic              repeat_reg;
    logic              repeat_next;

    logic              accept;
    logic              is_flush;
    logic              frame_done;
    logic              last_col;
    logic              frame_step;
    logic              start_repeat;
    logic [ROW_W-1:0]  h_row;
    logic [SUM_W-1:0]  sum;

    assign h_row      = ROW_W'(height);
    assign is_flush   = (in_data.opcode == OP_FLUSH);
    assign frame_done = (row_reg >= h_row);

    // A repeated step is the second virtual advance of a flush in a one-row frame.
    assign in_stall = repeat_reg || !take;
    assign accept   = in_valid && !in_stall;
    assign issue    = repeat_reg ? take : (accept && (is_flush == frame_done));

    assign sum = SUM_W'(in_data.red) + SUM_W'(in_data.green) + SUM_W'(in_data.blue);

    assign last_col   = ((WID_W'(col_reg) + WID_W'(1)) == width);
    assign frame_step = (col_reg == '0) && (row_reg == (h_row + ROW_W'(1)));

    // The only position that yields no output during a flush is the first of row one.
    assign start_repeat = !repeat_reg && is_flush && (row_reg == ROW_W'(1)) && (col_reg == '0);

    always_comb
    begin
        step.real_px   = !repeat_reg && !is_flush;
        step.px_bit    = !repeat_reg && !is_flush && (sum >= SUM_W'(threshold));
        step.top_en    = (row_reg >= ROW_W'(2));
        step.mid_en    = (row_reg != '0) && (row_reg <= h_row);
        step.col_zero  = (col_reg == '0);
        step.due       = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && (col_reg != '0));
        step.frame_end = frame_step;
    end

    assign step_addr = col_reg;

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        repeat_next = repeat_reg;
        if (restart)
        begin
            col_next    = '0;
            row_next    = '0;
            repeat_next = 1'b0;
        end
        else if (issue)
        begin
            repeat_next = start_repeat;
            if (frame_step)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (last_col)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            repeat_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            repeat_reg <= repeat_next;
        end
    end

endmodule

// ===== design/btde_win.sv =====
// Window stage: line store write-back, 3x3 window, edge decision and output register.
module btde_win import btde_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              restart,
    input  logic              issue,
    input  step_ctl_t         step,
    input  logic [ADDR_W-1:0] step_addr,
    output logic              take,
    input  logic [MEM_W-1:0]  rd_data,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [MEM_W-1:0]  wr_data,
    output logic              out_valid,
    input  logic              out_stall,
    output edge_out_t         out_data
);

    logic              p1_valid_reg;
    logic              p1_valid_next;
    step_ctl_t         p1_ctl_reg;
    step_ctl_t         p1_ctl_next;
    logic [ADDR_W-1:0] p1_addr_reg;
    logic [ADDR_W-1:0] p1_addr_next;
    logic              fwd_hit_reg;
    logic              fwd_hit_next;
    logic [MEM_W-1:0]  fwd_data_reg;
    logic [MEM_W-1:0]  fwd_data_next;
    logic [WIN_W-1:0]  window_reg;
    logic [WIN_W-1:0]  window_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    edge_out_t         out_data_reg;
    edge_out_t         out_data_next;

    logic              out_free;
    logic              p1_go;
    logic [MEM_W-1:0]  mem_word;
    logic              older;
    logic              newer;
    logic [2:0]        column;
    logic [WIN_W-1:0]  shifted;
    logic [WIN_W-1:0]  win;
    logic              edge_bit;

    assign out_free = !out_valid_reg || !out_stall;
    assign p1_go    = p1_valid_reg && (!p1_ctl_reg.due || out_free);
    assign take     = !p1_valid_reg || p1_go;

    // A write to the same entry in the cycle of the read is not seen by that read.
    assign mem_word = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign older    = mem_word[1];
    assign newer    = mem_word[0];

    assign column = {p1_ctl_reg.real_px & p1_ctl_reg.px_bit,
                     p1_ctl_reg.mid_en & newer,
                     p1_ctl_reg.top_en & older};

    always_comb
    begin
        if (p1_ctl_reg.col_zero)
        begin
            // First column: the window still closes the previous row's last pixel.
            win     = {3'b000, window_reg[WIN_W-1:3]};
            shifted = {column, 6'b000000};
        end
        else
        begin
            shifted = {column, window_reg[WIN_W-1:3]};
            win     = shifted;
        end
    end

    assign edge_bit = (win != '0) && !win[4];

    assign wr_en   = p1_go && p1_ctl_reg.real_px;
    assign wr_addr = p1_addr_reg;
    assign wr_data = {newer, p1_ctl_reg.px_bit};

    always_comb
    begin
        p1_valid_next = p1_valid_reg;
        p1_ctl_next   = p1_ctl_reg;
        p1_addr_next  = p1_addr_reg;
        fwd_hit_next  = fwd_hit_reg;
        fwd_data_next = fwd_data_reg;
        if (issue)
        begin
            p1_valid_next = 1'b1;
            p1_ctl_next   = step;
            p1_addr_next  = step_addr;
            fwd_hit_next  = wr_en && (wr_addr == step_addr);
            fwd_data_next = wr_data;
        end
        else if (p1_go)
        begin
            p1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        window_next = window_reg;
        if (restart)
        begin
            window_next = '0;
        end
        else if (p1_go)
        begin
            window_next = p1_ctl_reg.frame_end ? '0 : shifted;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (p1_go && p1_ctl_reg.due)
        begin
            out_valid_next           = 1'b1;
            out_data_next.edge_value = edge_bit ? EDGE_ON : EDGE_OFF;
            out_data_next.line_end   = p1_ctl_reg.col_zero;
            out_data_next.frame_end  = p1_ctl_reg.frame_end;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            window_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg  <= p1_valid_next;
            window_reg    <= window_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_ctl_reg   <= p1_ctl_next;
        p1_addr_reg  <= p1_addr_next;
        fwd_hit_reg  <= fwd_hit_next;
        fwd_data_reg <= fwd_data_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/binary_threshold_dilate_edge.sv =====
// Top level: configuration registers, line store and the two pipeline stages.
//
//  Channel  Signals                                    Word
//  in       in_valid, in_stall, in_data                pixel_in_t (pixel or flush)
//  out      out_valid, out_stall, out_data             edge_out_t (one edge pixel)
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  register write
//
// One word is taken per clock while in_stall is low; the line store is read when a taken word
// issues a step and written back as the step leaves the window stage for the output register.
// The first flush of a one-row frame advances two positions and stalls the input while it repeats.
// Reset clears counters, window and valid flags; the line store needs no clearing
// pass because no entry's contents are used in a frame before that entry is written.
// A stalled output holds its word while one more word can still enter the pipeline.
module binary_threshold_dilate_edge import btde_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pixel_in_t            in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output edge_out_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int SZ_W   = (WID_W > HGT_W) ? WID_W : HGT_W;
    localparam int CMP_W  = (SZ_W > CFG_W) ? SZ_W : CFG_W;
    localparam int WIDTH_INIT  = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int HEIGHT_INIT = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

    logic [WID_W-1:0]  width_reg;
    logic [WID_W-1:0]  width_next;
    logic [HGT_W-1:0]  height_reg;
    logic [HGT_W-1:0]  height_next;
    logic [THR_W-1:0]  thr_reg;
    logic [THR_W-1:0]  thr_next;
    logic              restart;
    logic [CMP_W-1:0]  cfg_val;

    logic              take;
    logic              issue;
    step_ctl_t         step;
    logic [ADDR_W-1:0] step_addr;
    logic [MEM_W-1:0]  rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [MEM_W-1:0]  wr_data;

    assign cfg_ready = 1'b1;
    assign cfg_val   = CMP_W'(cfg_data);

    // Sizes are stored already clamped to one through the maximum.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        thr_next    = thr_reg;
        restart     = 1'b0;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    restart = 1'b1;
                    if (cfg_val == '0)
                        width_next = WID_W'(1);
                    else if (cfg_val > CMP_W'(MAX_WIDTH))
                        width_next = WID_W'(MAX_WIDTH);
                    else
                        width_next = WID_W'(cfg_val);
                end
                REG_IMAGE_HEIGHT:
                begin
                    restart = 1'b1;
                    if (cfg_val == '0)
                        height_next = HGT_W'(1);
                    else if (cfg_val > CMP_W'(MAX_HEIGHT))
                        height_next = HGT_W'(MAX_HEIGHT);
                    else
                        height_next = HGT_W'(cfg_val);
                end
                REG_SUM_THRESHOLD:
                begin
                    thr_next = cfg_data[THR_W-1:0];
                end
                default:
                begin
                    thr_next = thr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WID_W'(WIDTH_INIT);
            height_reg <= HGT_W'(HEIGHT_INIT);
            thr_reg    <= THR_W'(THR_RESET);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            thr_reg    <= thr_next;
        end
    end

    btde_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .width     (width_reg),
        .height    (height_reg),
        .threshold (thr_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .take      (take),
        .issue     (issue),
        .step      (step),
        .step_addr (step_addr)
    );

    btde_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .rd_en   (issue),
        .rd_addr (step_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    btde_win #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_win (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .issue     (issue),
        .step      (step),
        .step_addr (step_addr),
        .take      (take),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
